>>> hdl/montgomery_mul_cios_assert.svh
// Assertion macros shared by the Montgomery multiplier modules.
`ifndef MONTGOMERY_MUL_CIOS_ASSERT_SVH
`define MONTGOMERY_MUL_CIOS_ASSERT_SVH

// Implication that must hold on every clock edge outside reset.
`define MMC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define MMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mmc_pkg.sv
// Package: widths, phase codes and types of the Montgomery multiplier.
`timescale 1ns / 1ps
package mmc_pkg;
  localparam int MaxLimbs = 32;
  localparam int IdxW     = 5;
  localparam int CntW     = 6;
  localparam int WordW    = 32;

  localparam logic OP_MODULUS = 1'b0;
  localparam logic OP_OPERAND = 1'b1;

  localparam logic CFG_NEG_INV    = 1'b0;
  localparam logic CFG_LIMB_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_RED,
    ST_FIX,
    ST_SUB,
    ST_OUT
  } state_t;

  // Per-cycle control that the sequencer hands to the cell row.
  typedef struct packed {
    logic             clear;   // zero accumulator
    logic             mac;     // step of a[i]*b pass
    logic             red;     // step of m*N pass
    logic             first;   // first limb of a pass
    logic             shift;   // rotate accumulator by one cell
  } cell_ctrl_t;
endpackage

>>> hdl/mmc_cell.sv
// One accumulator cell: holds a 32-bit limb and passes it to its neighbour.
`timescale 1ns / 1ps
module mmc_cell
  import mmc_pkg::*;
(
  input  logic             clk,
  input  logic             clear,
  input  logic             load,
  input  logic [WordW-1:0] d,
  output logic [WordW-1:0] q
);
  always_ff @(posedge clk) begin
    if (clear) begin
      q <= '0;
    end else if (load) begin
      q <= d;
    end
  end
endmodule

>>> hdl/montgomery_mul_cios.sv
// Top level: CIOS Montgomery multiplier over a rotating row of limb cells.
`timescale 1ns / 1ps
// Montgomery multiplier, CIOS form, 32-bit limbs, up to 32 limbs.
// Load modulus limbs (op 0) and operand limb pairs (op 1) one per transaction;
// busy stays low during loads. The operand transaction
// marked last starts a product: busy rises and the block runs n outer rounds,
// each one pass for a[i]*b and one for m*N; those products go through one
// shared 32x32 multiplier, while m comes from a separate multiply by neg_inv.
// The accumulator is a ring of n+2 live cells that rotates one cell on each
// loading step, so the multiplier always sees cell 0. Trial subtraction and
// output follow; the last limb appears in the same cycle that busy falls.
// Results appear on result_word, result_index and result_last for exactly
// one cycle each, marked by result_valid, least significant first; the
// receiver cannot stall them.
// Configuration writes are always ready and must only come while idle.
module montgomery_mul_cios
  import mmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             op,
  input  logic [IdxW-1:0]  limb_index,
  input  logic [WordW-1:0] a_word,
  input  logic [WordW-1:0] b_word,
  input  logic [WordW-1:0] modulus_word,
  input  logic             last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [WordW-1:0] cfg_data,
  output logic             result_valid,
  output logic [WordW-1:0] result_word,
  output logic [IdxW-1:0]  result_index,
  output logic             result_last
);
  `include "montgomery_mul_cios_assert.svh"

  localparam int Cells = MaxLimbs + 2;

  // Configuration registers.
  logic [WordW-1:0] neg_inv;
  logic [CntW-1:0]  limb_count;
  logic [CntW-1:0]  n;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      neg_inv    <= '0;
      limb_count <= CntW'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NEG_INV:    neg_inv    <= cfg_data;
        CFG_LIMB_COUNT: limb_count <= cfg_data[CntW-1:0];
        default:        ;
      endcase
    end
  end

  // Saturate the limb count to 1..32.
  always_comb begin
    if (limb_count == '0) begin
      n = CntW'(1);
    end else if (limb_count > CntW'(MaxLimbs)) begin
      n = CntW'(MaxLimbs);
    end else begin
      n = limb_count;
    end
  end

  // Operand and modulus memories, registered read.
  logic [WordW-1:0] mem_a [MaxLimbs];
  logic [WordW-1:0] mem_b [MaxLimbs];
  logic [WordW-1:0] mem_n [MaxLimbs];
  logic [IdxW-1:0]  rd_b, rd_n, rd_a;
  logic [WordW-1:0] b_q, n_q, a_q;

  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept && op == OP_MODULUS) begin
      mem_n[limb_index] <= modulus_word;
    end
    if (accept && op == OP_OPERAND) begin
      mem_a[limb_index] <= a_word;
      mem_b[limb_index] <= b_word;
    end
    b_q <= mem_b[rd_b];
    n_q <= mem_n[rd_n];
    a_q <= mem_a[rd_a];
  end

  // Sequencer state.
  state_t           state, state_next;
  logic [CntW-1:0]  i, i_next;   // outer round
  logic [CntW-1:0]  j, j_next;   // step within a pass
  logic [WordW-1:0] carry, carry_next;
  logic [WordW-1:0] m, m_next;
  logic             borrow, borrow_next;
  logic             do_sub;
  cell_ctrl_t       ctrl;

  // Ring of accumulator cells; cell 0 is the one being worked on.
  logic [WordW-1:0] cq [Cells];
  logic [WordW-1:0] cd [Cells];
  logic [WordW-1:0] c0_new;
  logic             ring_load;

  // Difference limbs are kept in an array indexed by limb position.
  logic [WordW-1:0] diff [MaxLimbs];

  // Shared multiplier: one 32x32 product plus two 32-bit addends.
  logic [WordW-1:0]   mul_x;
  logic [WordW-1:0]   mul_y;
  logic [2*WordW+1:0] sum;
  logic [2*WordW-1:0] prod;

  always_comb begin
    mul_x = (state == ST_MAC) ? a_q : m;
    mul_y = (state == ST_MAC) ? b_q : n_q;
    prod  = 64'(mul_x) * 64'(mul_y);
    sum   = 66'(prod) + 66'(cq[0]) + 66'(carry);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && op == OP_OPERAND && last) state_next = ST_MAC;
      ST_MAC:  if (j == n + CntW'(1)) state_next = ST_RED;
      ST_RED:  if (j == n + CntW'(1)) begin
                 state_next = (i == n - CntW'(1)) ? ST_SUB : ST_MAC;
               end
      ST_FIX:  state_next = ST_SUB;
      ST_SUB:  if (j == n) state_next = ST_OUT;
      ST_OUT:  if (j == n - CntW'(1)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory read addresses lead the data they feed, as the reads are registered.
  always_comb begin
    rd_a = i[IdxW-1:0];
    rd_b = j[IdxW-1:0];
    rd_n = j[IdxW-1:0];
  end

  // Datapath control.
  // MAC pass, j=0: fetch; j=1..n: cell 0 += a*b + carry, rotate; j=n+1:
  // fold carry into cell n (now cell 0) and n+1, rotate back to start.
  // Rotation: n+2 live cells; positions beyond that are unused.
  always_comb begin
    ctrl        = '0;
    i_next      = i;
    j_next      = j + CntW'(1);
    carry_next  = carry;
    m_next      = m;
    borrow_next = borrow;
    c0_new      = cq[0];
    ring_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        j_next     = '0;
        i_next     = '0;
        carry_next = '0;
        ctrl.clear = accept && op == OP_OPERAND && last;
      end
      ST_MAC: begin
        if (j == '0) begin
          carry_next = '0;
        end else if (j <= n) begin
          c0_new     = sum[WordW-1:0];
          carry_next = sum[2*WordW-1:WordW];
          ring_load  = 1'b1;
        end else begin
          // cell0 = t[n], cell1 = t[n+1]
          ring_load  = 1'b1;
          j_next     = '0;
          carry_next = '0;
        end
      end
      ST_RED: begin
        if (j == '0) begin
          m_next     = cq[0] * neg_inv;
          carry_next = '0;
        end else if (j <= n) begin
          c0_new     = sum[WordW-1:0];
          carry_next = sum[2*WordW-1:WordW];
          ring_load  = 1'b1;
        end else begin
          ring_load  = 1'b1;
          j_next     = '0;
          carry_next = '0;
          i_next     = i + CntW'(1);
        end
      end
      ST_SUB: begin
        if (j == '0) begin
          borrow_next = 1'b0;
        end else begin
          ring_load   = 1'b1;
          borrow_next = (33'(cq[0]) < 33'(n_q) + 33'(borrow));
        end
        if (j == n) j_next = '0;
      end
      ST_OUT: begin
        ring_load = 1'b1;
      end
      default: ;
    endcase
  end

  // Ring wiring: rotate left over n+2 cells (cell k takes cell k+1).
  // In the final MAC/RED step the carry is folded into t[n] and t[n+1];
  // in RED the dropped low limb makes the ring shift one limb down.
  logic [CntW:0] top;
  assign top = {1'b0, n} + 7'd1;   // index of t[n+1]

  logic [WordW:0] fold_lo;
  logic [WordW:0] fold_hi;
  always_comb begin
    fold_lo = 33'(cq[0]) + 33'(carry);
    fold_hi = 33'(cq[1]) + 33'(fold_lo[WordW]);
  end

  logic end_pass;
  assign end_pass = (state == ST_MAC || state == ST_RED) && j == n + CntW'(1);

  always_comb begin
    for (int k = 0; k < Cells; k++) begin
      if (7'(k) < top) begin
        cd[k] = cq[k + 1 < Cells ? k + 1 : 0];
      end else begin
        cd[k] = '0;
      end
      if (7'(k) == top) begin
        cd[k] = c0_new;
      end
    end
    if (end_pass) begin
      // ring currently at cell0=t[n], cell1=t[n+1], cell2..=t[0..]
      for (int k = 0; k < Cells; k++) begin
        if (7'(k) + 7'd2 <= top) cd[k] = cq[k + 2 < Cells ? k + 2 : 0];
        else cd[k] = '0;
      end
      if (state == ST_MAC) begin
        cd[top[CntW-1:0] - CntW'(1)] = fold_lo[WordW-1:0];
        cd[top[CntW-1:0]]            = fold_hi[WordW-1:0];
      end else begin
        // drop t[0] (now at position 0 after realignment), shift by one
        for (int k = 0; k < Cells; k++) begin
          if (7'(k) + 7'd3 <= top) cd[k] = cq[k + 3 < Cells ? k + 3 : 0];
          else cd[k] = '0;
        end
        cd[top[CntW-1:0] - CntW'(2)] = fold_lo[WordW-1:0];
        cd[top[CntW-1:0] - CntW'(1)] = fold_hi[WordW-1:0];
        cd[top[CntW-1:0]]            = {{(WordW-1){1'b0}}, fold_hi[WordW]};
      end
    end
  end

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    mmc_cell u_cell (
      .clk   (clk),
      .clear (ctrl.clear),
      .load  (ring_load),
      .d     (cd[g]),
      .q     (cq[g])
    );
  end

  // In SUB, step j sees t[j-1] at cell 0; at the last step t[n] and t[n+1]
  // sit at cells 1 and 2. After SUB the ring has turned n cells, so during
  // output t[j] sits at cell 2.
  always_ff @(posedge clk) begin
    if (state == ST_SUB && j != '0) begin
      diff[j[IdxW-1:0] - IdxW'(1)] <= cq[0] - n_q - WordW'(borrow);
    end
  end

  assign do_sub = (cq[1] != '0) || (cq[2] != '0) || !borrow_next;

  logic sub_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      i            <= '0;
      j            <= '0;
      carry        <= '0;
      m            <= '0;
      borrow       <= 1'b0;
      sub_sel      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      i            <= i_next;
      j            <= j_next;
      carry        <= carry_next;
      m            <= m_next;
      borrow       <= borrow_next;
      result_valid <= (state == ST_OUT);
      if (state == ST_SUB && j == n) begin
        sub_sel <= do_sub;
      end
    end
  end

  always_ff @(posedge clk) begin
    result_word  <= sub_sel ? diff[j[IdxW-1:0]] : cq[2];
    result_index <= j[IdxW-1:0];
    result_last  <= (j == n - CntW'(1));
  end

  assign busy = (state != ST_IDLE);

  `MMC_ASSERT_NEXT(a_start_busy, clk, rst,
    accept && op == OP_OPERAND && last, busy, "product did not start")
  `MMC_ASSERT_IMPL(a_no_accept_busy, clk, rst,
    result_valid, busy || $past(state) == ST_OUT, "result outside output phase")
  `MMC_ASSERT_IMPL(a_idx_range, clk, rst,
    state == ST_OUT, j < n, "output index past limb count")
endmodule
